>>> rtl/hrd_pkg.sv
// Shared types, character codes and helpers of the hex record decoder.
`timescale 1ns / 1ps
`default_nettype none
package hrd_pkg;

  localparam logic [7:0] ChColon   = 8'd58;
  localparam logic [7:0] ChNewline = 8'd10;

  localparam logic [1:0] PhStart  = 2'd0;
  localparam logic [1:0] PhRecord = 2'd1;
  localparam logic [1:0] PhSkip   = 2'd2;
  localparam logic [1:0] PhStop   = 2'd3;

  localparam logic [8:0] PosLength   = 9'd0;
  localparam logic [8:0] PosAddrHigh = 9'd1;
  localparam logic [8:0] PosAddrLow  = 9'd2;
  localparam logic [8:0] PosType     = 9'd3;
  localparam logic [8:0] PosData     = 9'd4;

  localparam logic [7:0] RecData = 8'd0;
  localparam logic [7:0] RecEof  = 8'd1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOF   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  phase;
    logic        nibble_pending;
    logic [3:0]  high_nibble;
    logic [8:0]  byte_position;
    logic [7:0]  record_length;
    logic [15:0] record_address;
    logic [7:0]  record_type;
  } state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [16:0] byte_address;
    logic [7:0]  data_byte;
  } result_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      n = 4'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      n = 4'(c - 8'd55);
    end else if (c >= 8'd97 && c <= 8'd102) begin
      n = 4'(c - 8'd87);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hrd_step.sv
// Next-state and result logic for one character of the hex record decoder.
`timescale 1ns / 1ps
`default_nettype none
module hrd_step (
  input  wire hrd_pkg::state_t  state_i,
  input  wire logic [7:0]       char_i,
  output hrd_pkg::state_t       state_o,
  output hrd_pkg::result_t      res_o
);

  logic [7:0]  value;
  logic [8:0]  data_end;
  logic [8:0]  data_index;
  logic [16:0] data_addr;

  assign value      = {state_i.high_nibble, hrd_pkg::nibble_of(char_i)};
  assign data_end   = {1'b0, state_i.record_length} + hrd_pkg::PosData;
  assign data_index = state_i.byte_position - hrd_pkg::PosData;
  assign data_addr  = {1'b0, state_i.record_address} + {8'd0, data_index};

  always_comb begin
    state_o = state_i;
    res_o   = '{valid: 1'b0, kind: hrd_pkg::KIND_DATA, byte_address: '0, data_byte: '0};
    priority if (state_i.phase == hrd_pkg::PhStop) begin
      state_o = state_i;
    end else if (state_i.phase == hrd_pkg::PhStart) begin
      if (char_i == hrd_pkg::ChColon) begin
        state_o       = '0;
        state_o.phase = hrd_pkg::PhRecord;
      end else begin
        state_o.phase = hrd_pkg::PhStop;
        res_o.valid   = 1'b1;
        res_o.kind    = hrd_pkg::KIND_ERROR;
      end
    end else if (char_i == hrd_pkg::ChNewline) begin
      state_o.phase          = hrd_pkg::PhStart;
      state_o.nibble_pending = 1'b0;
    end else if (state_i.phase == hrd_pkg::PhSkip) begin
      state_o = state_i;
    end else if (!state_i.nibble_pending) begin
      state_o.high_nibble    = hrd_pkg::nibble_of(char_i);
      state_o.nibble_pending = 1'b1;
    end else begin
      state_o.nibble_pending = 1'b0;
      state_o.byte_position  = state_i.byte_position + 9'd1;
      priority if (state_i.byte_position == hrd_pkg::PosLength) begin
        state_o.record_length = value;
      end else if (state_i.byte_position == hrd_pkg::PosAddrHigh) begin
        state_o.record_address = {value, 8'd0};
      end else if (state_i.byte_position == hrd_pkg::PosAddrLow) begin
        state_o.record_address = {state_i.record_address[15:8], value};
      end else if (state_i.byte_position == hrd_pkg::PosType) begin
        state_o.record_type = value;
        if (value == hrd_pkg::RecEof) begin
          state_o.phase = hrd_pkg::PhStop;
          res_o.valid   = 1'b1;
          res_o.kind    = hrd_pkg::KIND_EOF;
        end
      end else if (state_i.byte_position < data_end) begin
        if (state_i.record_type == hrd_pkg::RecData) begin
          res_o.valid        = 1'b1;
          res_o.kind         = hrd_pkg::KIND_DATA;
          res_o.byte_address = data_addr;
          res_o.data_byte    = value;
        end
      end else begin
        state_o.phase = hrd_pkg::PhSkip;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/hex_record_stream_decoder.sv
// Top level of the hex record decoder: input register, decode state, result register.
// A result is registered: input register, then decode step, then result register.
// Throughput: one character per cycle unless a result waits on the master side.
// Decode state updates once per character; it and the input hold while a result waits.
// Reset clears the decode state to awaiting start of line and empties both registers.
`timescale 1ns / 1ps
`default_nettype none
module hex_record_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [16:0] byte_address, [24:17] data_byte, zero
  output logic [1:0]       m_axis_tuser    // [1:0] kind
);

  logic             in_valid_q;
  logic [7:0]       in_char_q;
  logic             advance;
  hrd_pkg::state_t  state_q;
  hrd_pkg::state_t  state_d;
  hrd_pkg::result_t res;
  logic             out_valid_q;
  logic             out_valid_d;
  hrd_pkg::kind_e   out_kind_q;
  logic [16:0]      out_addr_q;
  logic [7:0]       out_data_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  hrd_step u_step (
    .state_i(state_q),
    .char_i (in_char_q),
    .state_o(state_d),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (advance) begin
      out_valid_d = res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
    end
    if (advance && res.valid) begin
      out_kind_q <= res.kind;
      out_addr_q <= res.byte_address;
      out_data_q <= res.data_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q, out_addr_q};
  assign m_axis_tuser  = out_kind_q;

endmodule
`default_nettype wire
